@@ rtl/kvfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Key-value field extractor package
// Shared constants, register indexes, the result record and the pattern
// character selection used by the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package kvfe_pkg;

    localparam int MAX_BODY_DEF  = 256;
    localparam int MAX_KEY_DEF   = 8;
    localparam int MAX_DELIM_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_DELIM_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_DELIM_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KV_DELIM_BYTES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KV_DELIM_LENGTH   = 3'd5;

    typedef struct packed {
        logic       found;
        logic [7:0] value_start;
        logic [8:0] value_length;
        logic       overflow;
    } res_t;

    // Character k of the combined pattern: pair delimiter, key, key-value delimiter.
    function automatic logic [7:0] pat_char(
        input logic [63:0] key,
        input logic [31:0] pd,
        input logic [31:0] kvd,
        input logic [2:0]  pl,
        input logic [3:0]  kl,
        input logic [4:0]  k
    );
        logic [4:0] kp;
        logic [4:0] kk;
        kp = k - {2'b00, pl};
        kk = kp - {1'b0, kl};
        if (k < {2'b00, pl}) begin
            return pd[{k[1:0], 3'b000} +: 8];
        end
        else if (kp < {1'b0, kl}) begin
            return key[{kp[2:0], 3'b000} +: 8];
        end
        else begin
            return kvd[{kk[1:0], 3'b000} +: 8];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/kvfe_body_mem.sv @@
// ----------------------------------------------------------------------------
// Body string memory
// Single write port and one registered read port holding the body bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module kvfe_body_mem #(
    parameter int DEPTH = kvfe_pkg::MAX_BODY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/kvfe_search.sv @@
// ----------------------------------------------------------------------------
// Key-value search sequencer
// Walks the stored body with one shared byte comparator, first for key plus kv delimiter
// at the start, then for pair delimiter, key and kv delimiter, then for the value's end.
// ----------------------------------------------------------------------------
`default_nettype none

module kvfe_search #(
    parameter int MAX_BODY  = kvfe_pkg::MAX_BODY_DEF,
    parameter int MAX_KEY   = kvfe_pkg::MAX_KEY_DEF,
    parameter int MAX_DELIM = kvfe_pkg::MAX_DELIM_DEF,
    parameter int AW        = $clog2(MAX_BODY),
    parameter int CW        = $clog2(MAX_BODY + 1)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [CW-1:0]   cnt_in,
    input  wire logic            ovf_in,
    input  wire logic [63:0]     key_bytes,
    input  wire logic [3:0]      key_length,
    input  wire logic [31:0]     pair_delim_bytes,
    input  wire logic [2:0]      pair_delim_length,
    input  wire logic [31:0]     kv_delim_bytes,
    input  wire logic [2:0]      kv_delim_length,
    output logic      [AW-1:0]   rd_addr,
    input  wire logic [7:0]      rd_data,
    output logic                 res_valid,
    output kvfe_pkg::res_t       res,
    input  wire logic            take
);

    localparam int          KEY_CAP   = (MAX_KEY < 8) ? MAX_KEY : 8;
    localparam int          DELIM_CAP = (MAX_DELIM < 4) ? MAX_DELIM : 4;
    localparam logic [3:0]  KEY_CAP_V = 4'(KEY_CAP);
    localparam logic [2:0]  DEL_CAP_V = 3'(DELIM_CAP);

    typedef enum logic [2:0] {
        E_IDLE,
        E_CHECK,
        E_TRY,
        E_RD,
        E_CMP,
        E_DONE
    } state_t;

    typedef enum logic [1:0] {
        M_KD,
        M_PKD,
        M_PD
    } mode_t;

    state_t         state_reg, state_next;
    mode_t          mode_reg, mode_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  vs_reg, vs_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [4:0]     j_reg, j_next;
    logic [7:0]     c_reg, c_next;
    logic [3:0]     kl_reg, kl_next;
    logic [2:0]     pl_reg, pl_next;
    logic [2:0]     dl_reg, dl_next;
    logic           ovf_reg, ovf_next;
    kvfe_pkg::res_t res_reg, res_next;

    logic [4:0]     pat_len;
    logic [4:0]     pat_ofs;
    logic [CW-1:0]  remain;
    logic [CW:0]    pos_plus_len;
    logic [CW:0]    pos_plus_one;
    logic [CW-1:0]  addr_sum;
    logic           fail;
    logic           pass;
    logic [CW+8:0]  start_ext;
    logic [CW+8:0]  len_hit_ext;
    logic [CW+8:0]  len_end_ext;

    always_comb
    begin
        case (mode_reg)
            M_KD:    pat_len = {1'b0, kl_reg} + {2'b00, dl_reg};
            M_PKD:   pat_len = {2'b00, pl_reg} + {1'b0, kl_reg} + {2'b00, dl_reg};
            default: pat_len = {2'b00, pl_reg};
        endcase
        pat_ofs = (mode_reg == M_KD) ? {2'b00, pl_reg} : 5'd0;
    end

    assign remain       = cnt_reg - pos_reg;
    assign pos_plus_len = {1'b0, pos_reg} + (CW+1)'(pat_len);
    assign pos_plus_one = {1'b0, pos_reg} + (CW+1)'(1);
    assign addr_sum     = pos_reg + CW'(j_reg);
    assign rd_addr      = addr_sum[AW-1:0];
    assign start_ext    = (CW+9)'(vs_reg);
    assign len_hit_ext  = (CW+9)'(pos_reg - vs_reg);
    assign len_end_ext  = (CW+9)'(cnt_reg - vs_reg);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        vs_next    = vs_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        c_next     = c_reg;
        kl_next    = kl_reg;
        pl_next    = pl_reg;
        dl_next    = dl_reg;
        ovf_next   = ovf_reg;
        res_next   = res_reg;
        fail       = 1'b0;
        pass       = 1'b0;

        case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = cnt_in;
                    ovf_next   = ovf_in;
                    kl_next    = (key_length > KEY_CAP_V) ? KEY_CAP_V : key_length;
                    pl_next    = (pair_delim_length > DEL_CAP_V) ? DEL_CAP_V
                                                                 : pair_delim_length;
                    dl_next    = (kv_delim_length > DEL_CAP_V) ? DEL_CAP_V
                                                               : kv_delim_length;
                    state_next = E_CHECK;
                end
            end
            E_CHECK:
            begin
                res_next = '{found: 1'b0, value_start: 8'd0, value_length: 9'd0,
                             overflow: ovf_reg};
                if (ovf_reg || cnt_reg == '0 || kl_reg == '0 || pl_reg == '0 ||
                    dl_reg == '0 || key_bytes[7:0] == 8'd0 ||
                    pair_delim_bytes[7:0] == 8'd0 || kv_delim_bytes[7:0] == 8'd0)
                begin
                    state_next = E_DONE;
                end
                else
                begin
                    mode_next  = M_KD;
                    pos_next   = '0;
                    state_next = E_TRY;
                end
            end
            E_TRY:
            begin
                if (CW'(pat_len) > remain)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    j_next     = 5'd0;
                    state_next = E_RD;
                end
            end
            E_RD:
            begin
                c_next = kvfe_pkg::pat_char(key_bytes, pair_delim_bytes, kv_delim_bytes,
                                            pl_reg, kl_reg, pat_ofs + j_reg);
                state_next = E_CMP;
            end
            E_CMP:
            begin
                if (c_reg == 8'd0 || rd_data != c_reg)
                begin
                    fail = 1'b1;
                end
                else if (j_reg == pat_len - 5'd1)
                begin
                    pass = 1'b1;
                end
                else
                begin
                    j_next     = j_reg + 5'd1;
                    state_next = E_RD;
                end
            end
            E_DONE:
            begin
                if (take)
                begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (fail)
        begin
            case (mode_reg)
                M_KD:
                begin
                    mode_next  = M_PKD;
                    pos_next   = '0;
                    state_next = E_TRY;
                end
                M_PKD:
                begin
                    if (pos_plus_one >= {1'b0, cnt_reg})
                    begin
                        state_next = E_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_plus_one[CW-1:0];
                        state_next = E_TRY;
                    end
                end
                default:
                begin
                    if (pos_plus_one >= {1'b0, cnt_reg})
                    begin
                        res_next.found        = 1'b1;
                        res_next.value_start  = start_ext[7:0];
                        res_next.value_length = len_end_ext[8:0];
                        state_next            = E_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_plus_one[CW-1:0];
                        state_next = E_TRY;
                    end
                end
            endcase
        end

        if (pass)
        begin
            case (mode_reg)
                M_KD, M_PKD:
                begin
                    if (pos_plus_len >= {1'b0, cnt_reg})
                    begin
                        state_next = E_DONE;
                    end
                    else
                    begin
                        mode_next  = M_PD;
                        pos_next   = pos_plus_len[CW-1:0];
                        vs_next    = pos_plus_len[CW-1:0];
                        state_next = E_TRY;
                    end
                end
                default:
                begin
                    if (pos_reg != vs_reg)
                    begin
                        res_next.found        = 1'b1;
                        res_next.value_start  = start_ext[7:0];
                        res_next.value_length = len_hit_ext[8:0];
                    end
                    state_next = E_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            mode_reg  <= M_KD;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        vs_reg  <= vs_next;
        cnt_reg <= cnt_next;
        j_reg   <= j_next;
        c_reg   <= c_next;
        kl_reg  <= kl_next;
        pl_reg  <= pl_next;
        dl_reg  <= dl_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
    end

    assign res_valid = (state_reg == E_DONE);
    assign res       = res_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == E_IDLE)
        else $error("Search started while the sequencer was busy.");

    a_read_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == E_RD |-> addr_sum < cnt_reg)
        else $error("Body read beyond the stored characters.");

    a_found_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> !res.overflow && res.value_length != 9'd0)
        else $error("Found result with overflow or empty value.");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.value_start == 8'd0 && res.value_length == 9'd0)
        else $error("Absent result carries a nonzero offset or length.");

endmodule

`default_nettype wire

@@ rtl/key_value_field_extractor_top.sv @@
// ----------------------------------------------------------------------------
// Key-value field extractor
// Body bytes are accepted one per cycle with no result; a transaction with
// last_byte set starts the lookup, and in_ready stays low until it finishes.
// The lookup tries body positions one after another and compares at most 16
// pattern characters at each; one shared byte comparator checks each body byte
// read from the body memory against the registered pattern character.
// Reset clears control and configuration registers; the body memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_field_extractor_top #(
    parameter int MAX_BODY  = kvfe_pkg::MAX_BODY_DEF,
    parameter int MAX_KEY   = kvfe_pkg::MAX_KEY_DEF,
    parameter int MAX_DELIM = kvfe_pkg::MAX_DELIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [kvfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kvfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      body_byte,
    input  wire logic                            last_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic [7:0]                           value_start,
    output logic [8:0]                           value_length,
    output logic                                 overflow
);

    localparam int            AW      = $clog2(MAX_BODY);
    localparam int            CW      = $clog2(MAX_BODY + 1);
    localparam logic [CW-1:0] BODY_CAP = CW'(MAX_BODY);

    logic [63:0]    key_bytes_reg;
    logic [3:0]     key_length_reg;
    logic [31:0]    pair_delim_bytes_reg;
    logic [2:0]     pair_delim_length_reg;
    logic [31:0]    kv_delim_bytes_reg;
    logic [2:0]     kv_delim_length_reg;

    logic [CW-1:0]  count_reg, count_next;
    logic           ended_reg, ended_next;
    logic           ovf_reg, ovf_next;
    logic           busy_reg, busy_next;
    logic           out_valid_reg, out_valid_next;
    kvfe_pkg::res_t out_res_reg, out_res_next;

    logic           accept;
    logic           live_char;
    logic           store;
    logic [CW-1:0]  cnt_after;
    logic           ovf_after;
    logic           start;
    logic           take;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;
    logic           res_valid;
    kvfe_pkg::res_t res;

    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;
    assign live_char = accept && !ended_reg && body_byte != 8'd0;
    assign store     = live_char && count_reg < BODY_CAP;
    assign cnt_after = store ? count_reg + CW'(1) : count_reg;
    assign ovf_after = ovf_reg || (live_char && count_reg >= BODY_CAP);
    assign start     = accept && last_byte;
    assign take      = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        count_next     = cnt_after;
        ovf_next       = ovf_after;
        ended_next     = ended_reg || (accept && body_byte == 8'd0);
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (start)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            ended_next = 1'b0;
            busy_next  = 1'b1;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
            busy_next      = 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg         <= '0;
            key_length_reg        <= '0;
            pair_delim_bytes_reg  <= '0;
            pair_delim_length_reg <= '0;
            kv_delim_bytes_reg    <= '0;
            kv_delim_length_reg   <= '0;
            count_reg             <= '0;
            ended_reg             <= 1'b0;
            ovf_reg               <= 1'b0;
            busy_reg              <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    kvfe_pkg::REG_KEY_BYTES:         key_bytes_reg <= cfg_data;
                    kvfe_pkg::REG_KEY_LENGTH:        key_length_reg <= cfg_data[3:0];
                    kvfe_pkg::REG_PAIR_DELIM_BYTES:  pair_delim_bytes_reg <= cfg_data[31:0];
                    kvfe_pkg::REG_PAIR_DELIM_LENGTH: pair_delim_length_reg <= cfg_data[2:0];
                    kvfe_pkg::REG_KV_DELIM_BYTES:    kv_delim_bytes_reg <= cfg_data[31:0];
                    kvfe_pkg::REG_KV_DELIM_LENGTH:   kv_delim_length_reg <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end
            count_reg     <= count_next;
            ended_reg     <= ended_next;
            ovf_reg       <= ovf_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    kvfe_body_mem #(
        .DEPTH (MAX_BODY),
        .AW    (AW)
    ) u_body_mem (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (body_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kvfe_search #(
        .MAX_BODY  (MAX_BODY),
        .MAX_KEY   (MAX_KEY),
        .MAX_DELIM (MAX_DELIM),
        .AW        (AW),
        .CW        (CW)
    ) u_search (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .cnt_in            (cnt_after),
        .ovf_in            (ovf_after),
        .key_bytes         (key_bytes_reg),
        .key_length        (key_length_reg),
        .pair_delim_bytes  (pair_delim_bytes_reg),
        .pair_delim_length (pair_delim_length_reg),
        .kv_delim_bytes    (kv_delim_bytes_reg),
        .kv_delim_length   (kv_delim_length_reg),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .res_valid         (res_valid),
        .res               (res),
        .take              (take)
    );

    assign out_valid    = out_valid_reg;
    assign found        = out_res_reg.found;
    assign value_start  = out_res_reg.value_start;
    assign value_length = out_res_reg.value_length;
    assign overflow     = out_res_reg.overflow;

endmodule

`default_nettype wire
